// ===== src/gcse_pkg.sv =====
// ----------------------------------------------------------------------------
// gcse_pkg
// Shared types, constants and command/status structs for the graph engine.
// ----------------------------------------------------------------------------
package gcse_pkg;

   localparam int MaxVertices = 32;
   localparam int VtxW        = $clog2(MaxVertices);
   localparam int CntW        = $clog2(MaxVertices + 1);

   typedef enum logic [1:0] {
      ACT_ADD_EDGE = 2'd0,
      ACT_CLEAR    = 2'd1,
      ACT_ACYCLIC  = 2'd2,
      ACT_SCC      = 2'd3
   } action_type;

   typedef struct packed {
      logic [1:0] action;
      logic [4:0] from_vertex;
      logic [4:0] to_vertex;
   } req_type;

   typedef struct packed {
      logic       result_kind;
      logic       is_acyclic;
      logic [5:0] component_count;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CLEAR,
      ST_START,
      ST_ROOT,
      ST_STEP,
      ST_PASS2,
      ST_POP,
      ST_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;          // capture request
      logic add_edge;
      logic clear_row;     // clear row at clear counter
      logic init_query;    // clear marks, stacks, counters
      logic root_try;      // examine root counter vertex
      logic step;          // one DFS step
      logic pass2_init;    // clear marks for second pass
      logic pop_try;       // pop finish order and maybe start a walk
      logic set_result;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clear_last;
      logic root_done;     // root counter reached n
      logic walk_empty;
      logic cycle_found;
      logic finish_empty;
      logic is_scc;
   } sts_type;

endpackage

// ===== src/graph_cycle_and_scc_engine.sv =====
// ----------------------------------------------------------------------------
// graph_cycle_and_scc_engine
// Directed graph store with acyclic check and strong component count.
// ----------------------------------------------------------------------------
// Edge loads stream back to back. A clear walks all 32 matrix rows, one per
// cycle. Queries run a depth-first walk with one stack step per cycle over
// the n active vertices. The component count runs two passes plus one pop
// per vertex. Input stalls during clears and queries; a finished result sits
// in an output register and is held until taken.
// ----------------------------------------------------------------------------
module graph_cycle_and_scc_engine (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  gcse_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gcse_pkg::rsp_type rsp_data,
   input  logic              csr_write_enable,
   input  logic [5:0]        csr_write_data
);

   logic [5:0]        vertex_count_ff;
   gcse_pkg::cmd_type cmd;
   gcse_pkg::sts_type sts;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= 6'd32;
      end else if (csr_write_enable) begin
         vertex_count_ff <= csr_write_data;
      end
   end

   gcse_control u_control (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_action (gcse_pkg::action_type'(req_data.action)),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .sts        (sts),
      .cmd        (cmd)
   );

   gcse_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .vertex_count (vertex_count_ff),
      .req_data     (req_data),
      .cmd          (cmd),
      .sts          (sts),
      .rsp_data     (rsp_data)
   );

endmodule

// ===== src/gcse_datapath.sv =====
// ----------------------------------------------------------------------------
// gcse_datapath
// Adjacency matrix, marks, walk stack and finish order with DFS step logic.
// ----------------------------------------------------------------------------
module gcse_datapath (
   input  logic                clock,
   input  logic                reset,
   input  logic [5:0]          vertex_count,
   input  gcse_pkg::req_type   req_data,
   input  gcse_pkg::cmd_type   cmd,
   output gcse_pkg::sts_type   sts,
   output gcse_pkg::rsp_type   rsp_data
);

   localparam int N = gcse_pkg::MaxVertices;
   localparam int VW = gcse_pkg::VtxW;
   localparam int CW = gcse_pkg::CntW;

   logic [N-1:0]  adj_ff [N];
   logic [N-1:0]  adj_in [N];
   logic [N-1:0]  visited_ff, visited_in;
   logic [N-1:0]  on_path_ff, on_path_in;
   logic [VW-1:0] stk_vtx_ff [N];
   logic [VW-1:0] stk_vtx_in [N];
   logic [CW-1:0] stk_nxt_ff [N];
   logic [CW-1:0] stk_nxt_in [N];
   logic [CW-1:0] depth_ff, depth_in;
   logic [VW-1:0] fin_ff [N];
   logic [VW-1:0] fin_in [N];
   logic [CW-1:0] fdepth_ff, fdepth_in;
   logic [CW-1:0] root_ff, root_in;
   logic [VW-1:0] clr_ff, clr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          cycle_ff, cycle_in;
   logic          transpose_ff, transpose_in;
   logic          record_ff, record_in;
   gcse_pkg::req_type req_ff, req_in;
   gcse_pkg::rsp_type rsp_ff, rsp_in;

   logic [CW-1:0] n;
   logic [VW-1:0] top_u;
   logic [CW-1:0] top_next;
   logic [N-1:0]  nbr;
   logic [N-1:0]  cand;
   logic          found;
   logic [VW-1:0] w;
   logic [VW-1:0] pop_u;

   assign n = (vertex_count > 6'(N)) ? CW'(N) : CW'(vertex_count);
   assign top_u    = stk_vtx_ff[VW'(depth_ff - CW'(1))];
   assign top_next = stk_nxt_ff[VW'(depth_ff - CW'(1))];
   assign pop_u    = fin_ff[VW'(fdepth_ff - CW'(1))];

   always_comb begin
      for (int i = 0; i < N; i++) begin
         nbr[i]  = transpose_ff ? adj_ff[i][top_u] : adj_ff[top_u][i];
         cand[i] = nbr[i] && (CW'(i) >= top_next) && (CW'(i) < n);
      end
      found = 1'b0;
      w = '0;
      for (int i = N - 1; i >= 0; i--) begin
         if (cand[i]) begin
            found = 1'b1;
            w = VW'(i);
         end
      end
   end

   always_comb begin
      adj_in       = adj_ff;
      visited_in   = visited_ff;
      on_path_in   = on_path_ff;
      stk_vtx_in   = stk_vtx_ff;
      stk_nxt_in   = stk_nxt_ff;
      depth_in     = depth_ff;
      fin_in       = fin_ff;
      fdepth_in    = fdepth_ff;
      root_in      = root_ff;
      clr_in       = clr_ff;
      count_in     = count_ff;
      cycle_in     = cycle_ff;
      transpose_in = transpose_ff;
      record_in    = record_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      if (cmd.load) begin
         req_in = req_data;
         clr_in = '0;
      end
      if (cmd.add_edge) begin
         if (CW'(req_ff.from_vertex) < n && CW'(req_ff.to_vertex) < n) begin
            adj_in[req_ff.from_vertex][req_ff.to_vertex] = 1'b1;
         end
      end
      if (cmd.clear_row) begin
         adj_in[clr_ff] = '0;
         clr_in = clr_ff + VW'(1);
      end
      if (cmd.init_query) begin
         visited_in   = '0;
         on_path_in   = '0;
         depth_in     = '0;
         fdepth_in    = '0;
         root_in      = '0;
         count_in     = '0;
         cycle_in     = 1'b0;
         transpose_in = 1'b0;
         record_in    = (req_ff.action == gcse_pkg::ACT_SCC);
      end
      if (cmd.pass2_init) begin
         visited_in   = '0;
         on_path_in   = '0;
         depth_in     = '0;
         transpose_in = 1'b1;
         record_in    = 1'b0;
      end
      if (cmd.root_try) begin
         if (!visited_ff[VW'(root_ff)]) begin
            visited_in[VW'(root_ff)] = 1'b1;
            on_path_in[VW'(root_ff)] = 1'b1;
            stk_vtx_in[0] = VW'(root_ff);
            stk_nxt_in[0] = '0;
            depth_in = CW'(1);
         end
         root_in = root_ff + CW'(1);
      end
      if (cmd.pop_try) begin
         fdepth_in = fdepth_ff - CW'(1);
         if (!visited_ff[pop_u]) begin
            visited_in[pop_u] = 1'b1;
            on_path_in[pop_u] = 1'b1;
            stk_vtx_in[0] = pop_u;
            stk_nxt_in[0] = '0;
            depth_in = CW'(1);
            count_in = count_ff + CW'(1);
         end
      end
      if (cmd.step) begin
         if (!found) begin
            on_path_in[top_u] = 1'b0;
            if (record_ff) begin
               fin_in[VW'(fdepth_ff)] = top_u;
               fdepth_in = fdepth_ff + CW'(1);
            end
            depth_in = depth_ff - CW'(1);
         end else begin
            stk_nxt_in[VW'(depth_ff - CW'(1))] = CW'(w) + CW'(1);
            if (!visited_ff[w]) begin
               visited_in[w] = 1'b1;
               on_path_in[w] = 1'b1;
               stk_vtx_in[VW'(depth_ff)] = w;
               stk_nxt_in[VW'(depth_ff)] = '0;
               depth_in = depth_ff + CW'(1);
            end else if (!record_ff && !transpose_ff && on_path_ff[w]) begin
               cycle_in = 1'b1;
               depth_in = '0;
            end
         end
      end
      if (cmd.set_result) begin
         rsp_in.result_kind     = (req_ff.action == gcse_pkg::ACT_SCC);
         rsp_in.is_acyclic      = (req_ff.action == gcse_pkg::ACT_SCC) ? 1'b0 : !cycle_ff;
         rsp_in.component_count = (req_ff.action == gcse_pkg::ACT_SCC) ? 6'(count_ff) : 6'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N; i++) begin
            adj_ff[i] <= '0;
         end
         visited_ff <= '0;
         on_path_ff <= '0;
         depth_ff   <= '0;
         fdepth_ff  <= '0;
         cycle_ff   <= 1'b0;
      end else begin
         adj_ff     <= adj_in;
         visited_ff <= visited_in;
         on_path_ff <= on_path_in;
         depth_ff   <= depth_in;
         fdepth_ff  <= fdepth_in;
         cycle_ff   <= cycle_in;
      end
   end

   always_ff @(posedge clock) begin
      stk_vtx_ff   <= stk_vtx_in;
      stk_nxt_ff   <= stk_nxt_in;
      fin_ff       <= fin_in;
      root_ff      <= root_in;
      clr_ff       <= clr_in;
      count_ff     <= count_in;
      transpose_ff <= transpose_in;
      record_ff    <= record_in;
      req_ff       <= req_in;
      rsp_ff       <= rsp_in;
   end

   assign sts.clear_last   = (clr_ff == VW'(N - 1));
   assign sts.root_done    = (root_ff >= n);
   assign sts.walk_empty   = (depth_ff == '0);
   assign sts.cycle_found  = cycle_ff;
   assign sts.finish_empty = (fdepth_ff == '0);
   assign sts.is_scc       = (req_ff.action == gcse_pkg::ACT_SCC);
   assign rsp_data         = rsp_ff;

endmodule

// ===== src/gcse_control.sv =====
// ----------------------------------------------------------------------------
// gcse_control
// Sequencer for edge loads, clears and the DFS query passes.
// ----------------------------------------------------------------------------
module gcse_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  gcse_pkg::action_type req_action,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   input  gcse_pkg::sts_type   sts,
   output gcse_pkg::cmd_type   cmd
);

   gcse_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic edge_ff, edge_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gcse_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         edge_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         edge_ff      <= edge_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      edge_in      = 1'b0;
      cmd          = '0;
      req_stall    = 1'b1;
      cmd.add_edge = edge_ff;
      unique case (state_ff)
         gcse_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               unique case (req_action)
                  gcse_pkg::ACT_ADD_EDGE: edge_in = 1'b1;
                  gcse_pkg::ACT_CLEAR:    state_in = gcse_pkg::ST_CLEAR;
                  default:                state_in = gcse_pkg::ST_START;
               endcase
            end
         end
         gcse_pkg::ST_CLEAR: begin
            cmd.clear_row = 1'b1;
            if (sts.clear_last) begin
               state_in = gcse_pkg::ST_IDLE;
            end
         end
         gcse_pkg::ST_START: begin
            cmd.init_query = 1'b1;
            state_in = gcse_pkg::ST_ROOT;
         end
         gcse_pkg::ST_ROOT: begin
            if (sts.cycle_found || sts.root_done) begin
               state_in = sts.is_scc ? gcse_pkg::ST_PASS2 : gcse_pkg::ST_DONE;
            end else begin
               cmd.root_try = 1'b1;
               state_in = gcse_pkg::ST_STEP;
            end
         end
         gcse_pkg::ST_STEP: begin
            if (sts.walk_empty) begin
               state_in = gcse_pkg::ST_ROOT;
            end else begin
               cmd.step = 1'b1;
            end
         end
         gcse_pkg::ST_PASS2: begin
            cmd.pass2_init = 1'b1;
            state_in = gcse_pkg::ST_POP;
         end
         gcse_pkg::ST_POP: begin
            if (!sts.walk_empty) begin
               cmd.step = 1'b1;
            end else if (sts.finish_empty) begin
               state_in = gcse_pkg::ST_DONE;
            end else begin
               cmd.pop_try = 1'b1;
            end
         end
         gcse_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.set_result = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = gcse_pkg::ST_IDLE;
            end
         end
         default: state_in = gcse_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== tb/tb_graph_cycle_and_scc_engine.sv =====
// ----------------------------------------------------------------------------
// tb_graph_cycle_and_scc_engine
// Self-checking bench for the graph engine: edge loads, clears, acyclic checks
// and strong component counts over several vertex counts, with a behavioral
// graph model predicting each answer and random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_graph_cycle_and_scc_engine;
   timeunit 1ns;
   timeprecision 1ps;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   gcse_pkg::req_type req_data = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   gcse_pkg::rsp_type rsp_data;
   logic              csr_write_enable = 1'b0;
   logic [5:0]        csr_write_data = '0;

   graph_cycle_and_scc_engine dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // graph model
   logic [31:0]       edge_rows [32];
   logic [5:0]        vtx_limit;
   gcse_pkg::rsp_type answer_queue [$];
   gcse_pkg::req_type pending_req [$];
   int                error_count = 0;
   int                sent_count = 0;
   int                answer_count = 0;
   int                query_count = 0;
   bit                stim_done = 1'b0;

   function automatic bit linked(int u, int w, bit transpose);
      return transpose ? edge_rows[w][u] : edge_rows[u][w];
   endfunction

   // depth-first walk; returns 1 on a back edge when detect is set
   function automatic bit dfs_walk(int start, int n, bit transpose, bit detect,
                                   ref logic [31:0] seen, ref logic [31:0] path,
                                   ref int order [$], input bit record);
      int stk_v [$];
      int stk_n [$];
      int u, w;
      seen[start] = 1'b1;
      path[start] = 1'b1;
      stk_v.push_back(start);
      stk_n.push_back(0);
      while (stk_v.size() > 0) begin
         u = stk_v[$];
         w = stk_n[$];
         while (w < n && !linked(u, w, transpose)) w++;
         if (w >= n) begin
            path[u] = 1'b0;
            if (record) order.push_back(u);
            void'(stk_v.pop_back());
            void'(stk_n.pop_back());
         end else begin
            stk_n[stk_n.size()-1] = w + 1;
            if (!seen[w]) begin
               seen[w] = 1'b1;
               path[w] = 1'b1;
               stk_v.push_back(w);
               stk_n.push_back(0);
            end else if (detect && path[w]) begin
               return 1'b1;
            end
         end
      end
      return 1'b0;
   endfunction

   function automatic gcse_pkg::rsp_type predict_answer(gcse_pkg::req_type r);
      gcse_pkg::rsp_type a;
      int                n;
      int                order [$];
      logic [31:0]       seen, path;
      int                u, cnt;
      a = '0;
      n = (vtx_limit > 32) ? 32 : vtx_limit;
      case (gcse_pkg::action_type'(r.action))
         gcse_pkg::ACT_ADD_EDGE: begin
            if (r.from_vertex < n && r.to_vertex < n)
               edge_rows[r.from_vertex][r.to_vertex] = 1'b1;
         end
         gcse_pkg::ACT_CLEAR: begin
            foreach (edge_rows[i]) edge_rows[i] = '0;
         end
         gcse_pkg::ACT_ACYCLIC: begin
            seen = '0; path = '0;
            a.is_acyclic = 1'b1;
            for (int v = 0; v < n; v++) begin
               if (!seen[v] && dfs_walk(v, n, 1'b0, 1'b1, seen, path, order, 1'b0)) begin
                  a.is_acyclic = 1'b0;
                  break;
               end
            end
         end
         default: begin
            seen = '0; path = '0; cnt = 0;
            a.result_kind = 1'b1;
            for (int v = 0; v < n; v++)
               if (!seen[v]) void'(dfs_walk(v, n, 1'b0, 1'b0, seen, path, order, 1'b1));
            seen = '0; path = '0;
            while (order.size() > 0) begin
               u = order.pop_back();
               if (!seen[u]) begin
                  void'(dfs_walk(u, n, 1'b1, 1'b0, seen, path, order, 1'b0));
                  cnt++;
               end
            end
            a.component_count = cnt[5:0];
         end
      endcase
      return a;
   endfunction

   function automatic bit is_query(gcse_pkg::req_type r);
      return (gcse_pkg::action_type'(r.action) == gcse_pkg::ACT_ACYCLIC) ||
             (gcse_pkg::action_type'(r.action) == gcse_pkg::ACT_SCC);
   endfunction

   task automatic report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      error_count++;
   endtask

   // driver: bursts with gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            if (is_query(req_data)) begin
               answer_queue.push_back(predict_answer(req_data));
               query_count++;
            end else begin
               void'(predict_answer(req_data));
            end
            sent_count++;
         end
         if (req_valid && req_stall) begin
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_req.size() > 0) begin
            req_data <= pending_req.pop_front();
            req_valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 20);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver stall pattern and monitor
   int stall_mode = 0;
   always @(posedge clock) begin
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 1) == 0);
         default: rsp_stall <= ($urandom_range(0, 7) != 0);
      endcase
      if (!reset && rsp_valid && !rsp_stall) begin
         answer_count++;
         if (answer_queue.size() == 0) begin
            report_mismatch("result with no query waiting");
         end else begin
            gcse_pkg::rsp_type e;
            e = answer_queue.pop_front();
            if (rsp_data.result_kind !== e.result_kind)
               report_mismatch($sformatf("result_kind %0b exp %0b",
                                         rsp_data.result_kind, e.result_kind));
            if (rsp_data.is_acyclic !== e.is_acyclic)
               report_mismatch($sformatf("is_acyclic %0b exp %0b",
                                         rsp_data.is_acyclic, e.is_acyclic));
            if (rsp_data.component_count !== e.component_count)
               report_mismatch($sformatf("component_count %0d exp %0d",
                                         rsp_data.component_count, e.component_count));
         end
      end
   end

   function automatic gcse_pkg::req_type make_req(gcse_pkg::action_type act, int f, int t);
      gcse_pkg::req_type r;
      r.action = act;
      r.from_vertex = f[4:0];
      r.to_vertex = t[4:0];
      return r;
   endfunction

   task automatic wait_idle();
      while (pending_req.size() > 0 || req_valid || answer_queue.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic set_vertex_count(int cnt);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= cnt[5:0];
      @(posedge clock);
      csr_write_enable <= 1'b0;
      vtx_limit = cnt[5:0];
   endtask

   // random graph: mix of structured chains/cycles and noise
   task automatic queue_random_graph(int n);
      int edges, f, t;
      pending_req.push_back(make_req(gcse_pkg::ACT_CLEAR, $urandom, $urandom));
      edges = $urandom_range(0, 2 * n + 2);
      for (int i = 0; i < edges; i++) begin
         f = $urandom_range(0, n > 0 ? n - 1 : 0);
         case ($urandom_range(0, 5))
            0: t = $urandom_range(0, 31);
            1: begin f = $urandom_range(0, 31); t = $urandom_range(0, 31); end
            2: t = f;
            3, 4: t = (f + 1 < n) ? f + 1 : 0;
            default: t = $urandom_range(0, n > 0 ? n - 1 : 0);
         endcase
         pending_req.push_back(make_req(gcse_pkg::ACT_ADD_EDGE, f, t));
         if ($urandom_range(0, 7) == 0)
            pending_req.push_back(make_req(($urandom_range(0, 1) == 0) ?
                                           gcse_pkg::ACT_ACYCLIC : gcse_pkg::ACT_SCC,
                                           $urandom, $urandom));
      end
      pending_req.push_back(make_req(gcse_pkg::ACT_ACYCLIC, $urandom, $urandom));
      pending_req.push_back(make_req(gcse_pkg::ACT_SCC, $urandom, $urandom));
   endtask

   int vcounts [8] = '{32, 1, 0, 63, 33, 8, 5, 16};

   initial begin
      foreach (edge_rows[i]) edge_rows[i] = '0;
      vtx_limit = 6'd32;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      // directed: empty graph, self-loop, extremes, chain, cycle
      pending_req.push_back(make_req(gcse_pkg::ACT_ACYCLIC, 31, 31));
      pending_req.push_back(make_req(gcse_pkg::ACT_SCC, 0, 0));
      pending_req.push_back(make_req(gcse_pkg::ACT_ADD_EDGE, 31, 31));
      pending_req.push_back(make_req(gcse_pkg::ACT_ACYCLIC, 0, 0));
      pending_req.push_back(make_req(gcse_pkg::ACT_SCC, 0, 0));
      pending_req.push_back(make_req(gcse_pkg::ACT_CLEAR, 31, 31));
      for (int i = 0; i < 31; i += 5)
         pending_req.push_back(make_req(gcse_pkg::ACT_ADD_EDGE, i, i + 1));
      pending_req.push_back(make_req(gcse_pkg::ACT_ADD_EDGE, 0, 0));
      pending_req.push_back(make_req(gcse_pkg::ACT_ADD_EDGE, 0, 1));
      pending_req.push_back(make_req(gcse_pkg::ACT_ACYCLIC, 0, 0));
      pending_req.push_back(make_req(gcse_pkg::ACT_ADD_EDGE, 31, 0));
      pending_req.push_back(make_req(gcse_pkg::ACT_ADD_EDGE, 1, 31));
      pending_req.push_back(make_req(gcse_pkg::ACT_ACYCLIC, 21, 10));
      pending_req.push_back(make_req(gcse_pkg::ACT_SCC, 10, 21));
      wait_idle();
      // count lowered after loading: stored edges above the limit stay hidden
      set_vertex_count(4);
      pending_req.push_back(make_req(gcse_pkg::ACT_ADD_EDGE, 3, 4));
      pending_req.push_back(make_req(gcse_pkg::ACT_ACYCLIC, 0, 0));
      pending_req.push_back(make_req(gcse_pkg::ACT_SCC, 0, 0));
      wait_idle();
      foreach (vcounts[k]) begin
         set_vertex_count(vcounts[k]);
         for (int g = 0; g < 6; g++) queue_random_graph(vcounts[k] > 32 ? 32 : vcounts[k]);
         wait_idle();
      end
      while (sent_count < 1350) begin
         set_vertex_count($urandom_range(0, 63));
         for (int g = 0; g < 3; g++) queue_random_graph(vtx_limit > 32 ? 32 : vtx_limit);
         wait_idle();
      end
      repeat (200) @(posedge clock);
      stim_done = 1'b1;
      $display("covered %0d transactions, %0d queries, %0d answers checked",
               sent_count, query_count, answer_count);
      $display("vertex counts from 0 to 63, self-loops, cycles, out-of-range edges");
      if (error_count == 0 && answer_queue.size() == 0)
         $display("graph_cycle_and_scc_engine regression: pass");
      else
         $display("graph_cycle_and_scc_engine regression: fail");
      $finish;
   end

   initial begin
      #20ms;
      $display("timeout");
      $display("graph_cycle_and_scc_engine regression: fail");
      $finish;
   end
endmodule
